[src/pdpr_pkg.sv]
// Shared types, constants and elaboration-time functions for the power dependent
// phase rotator. No dependencies; imported by the sine/cosine ROM and the core.
package pdpr_pkg;

  localparam int LUT_BITS_DEF    = 10;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int PHASE_BITS      = 16;
  localparam int TRIG_BITS       = 16;
  localparam int TRIG_FRAC       = 15;
  localparam int GAIN_BITS       = 24;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 24;

  localparam logic [63:0] HALFPI_Q62 = 64'h6487ED5110B4611A;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ENABLE       = 2'd0,
    CFG_PHASE_OFFSET = 2'd1,
    CFG_PHASE_GAIN   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int unsigned s);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod >> s);
  endfunction

  // Rounded 32767 * sin(pi/2 * r / 2^(lut_bits-2)), evaluated at elaboration only.
  function automatic logic [TRIG_BITS-1:0] quarter_sin(int unsigned r, int unsigned lut_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] t;
    x    = mul_shift(HALFPI_Q62, 64'(r), lut_bits - 2);
    x2   = mul_shift(x, x, 62);
    term = x;
    sum  = x;
    for (int unsigned n = 1; n <= 12; n++) begin
      term = mul_shift(term, x2, 62) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    t = mul_shift(sum, 64'd32767, 30);
    return TRIG_BITS'((t + 64'h8000_0000) >> 32);
  endfunction

endpackage

[src/pdpr_sincos_rom.sv]
// Quarter-wave sine table with a registered read that yields sin and cos
// magnitudes and the quadrant for one phase index. Depends on pdpr_pkg.
module pdpr_sincos_rom
  import pdpr_pkg::*;
#(
  parameter int LUT_BITS = LUT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic [LUT_BITS-1:0]  k,
  output logic [TRIG_BITS-1:0] s0,
  output logic [TRIG_BITS-1:0] c0,
  output quad_t                quad
);

  localparam int QUARTER = 1 << (LUT_BITS - 2);
  localparam int IW      = LUT_BITS - 1;

  logic [TRIG_BITS-1:0] tab [QUARTER+1];
  logic [IW-1:0]        s_idx;
  logic [IW-1:0]        c_idx;
  logic [TRIG_BITS-1:0] s0_r;
  logic [TRIG_BITS-1:0] c0_r;
  quad_t                quad_r;

  for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
    localparam logic [TRIG_BITS-1:0] VAL = quarter_sin(g, LUT_BITS);
    assign tab[g] = VAL;
  end

  assign s_idx = {1'b0, k[LUT_BITS-3:0]};
  assign c_idx = IW'(QUARTER) - s_idx;

  always_ff @(posedge clk) begin
    if (load) begin
      s0_r   <= tab[s_idx];
      c0_r   <= tab[c_idx];
      quad_r <= quad_t'(k[LUT_BITS-1:LUT_BITS-2]);
    end
  end

  assign s0   = s0_r;
  assign c0   = c0_r;
  assign quad = quad_r;

endmodule

[src/power_dependent_phase_rotator_core.sv]
// Power dependent phase rotator: eight-stage pipeline from power to rounded output.
// Depends on pdpr_pkg and pdpr_sincos_rom.
//
// Usage:
// The input channel takes one complex sample (in_i, in_q) per request, the
// output channel returns one rotated sample per request, in order. A request
// moves when valid is high and stall is low.
// The sample is rotated by phase_offset + (phase_gain * power >> (2*SAMPLE_BITS-2)),
// looked up in a quarter-wave table of 2^(LUT_BITS-2)+1 entries. With enable low
// the sample passes through unchanged, still with the same latency.
// One sample is taken per cycle while the output does not stall. Each of the
// eight register stages holds one multiply, one wide add or the table read.
// Each stage advances whenever it is empty or the stage after it advances, so
// a stall on the output fills empty stages first and only then stalls the input.
// Nothing is lost or repeated under stall.
// Reset empties the pipeline and clears enable, phase_offset and phase_gain.
// Registers are written through the cfg channel (always ready); an index beyond
// phase_gain is ignored. The user must write them only while no sample is in
// flight; the block itself does not enforce this.
module power_dependent_phase_rotator_core
  import pdpr_pkg::*;
#(
  parameter int LUT_BITS    = LUT_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   in_i,
  input  logic signed [SAMPLE_BITS-1:0]   in_q,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [SAMPLE_BITS-1:0]   out_i,
  output logic signed [SAMPLE_BITS-1:0]   out_q,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [CFG_DATA_BITS-1:0]        cfg_data
);

  localparam int W      = SAMPLE_BITS;
  localparam int NST    = 8;
  localparam int PSHIFT = 2 * W - 2;
  localparam int LPW    = GAIN_BITS + W + 1;
  localparam int MW     = 2 * W + GAIN_BITS + 1;
  localparam int PRW    = W + TRIG_BITS + 1;
  localparam int AW     = W + TRIG_BITS + 2;
  localparam int RW     = AW - TRIG_FRAC;

  logic                         enable_r;
  logic [PHASE_BITS-1:0]        phase_offset_r;
  logic signed [GAIN_BITS-1:0]  phase_gain_r;

  logic [NST-1:0]               vld_r;
  logic [NST-1:0]               en;

  logic signed [W-1:0]          xi_r [NST-1];
  logic signed [W-1:0]          xq_r [NST-1];

  logic signed [2*W-1:0]        sqi_r;
  logic signed [2*W-1:0]        sqq_r;
  logic [2*W-1:0]               p_nxt;
  logic [2*W-1:0]               p_r;
  logic signed [LPW-1:0]        plo_nxt;
  logic signed [LPW-1:0]        phi_nxt;
  logic signed [LPW-1:0]        plo_r;
  logic signed [LPW-1:0]        phi_r;
  logic signed [MW-1:0]         full;
  logic [PHASE_BITS-1:0]        phase;
  logic [LUT_BITS-1:0]          k_nxt;
  logic [LUT_BITS-1:0]          k_r;

  logic [TRIG_BITS-1:0]         s0;
  logic [TRIG_BITS-1:0]         c0;
  quad_t                        quad;

  logic signed [PRW-1:0]        mic_r;
  logic signed [PRW-1:0]        mis_r;
  logic signed [PRW-1:0]        mqc_r;
  logic signed [PRW-1:0]        mqs_r;
  quad_t                        quad5_r;
  logic signed [AW-1:0]         a_nxt;
  logic signed [AW-1:0]         b_nxt;
  logic signed [AW-1:0]         a_r;
  logic signed [AW-1:0]         b_r;
  quad_t                        quad6_r;

  logic signed [AW-1:0]         ri_sel;
  logic signed [AW-1:0]         rq_sel;
  logic signed [RW-1:0]         ri_rnd;
  logic signed [RW-1:0]         rq_rnd;
  logic signed [W-1:0]          out_i_nxt;
  logic signed [W-1:0]          out_q_nxt;
  logic signed [W-1:0]          out_i_r;
  logic signed [W-1:0]          out_q_r;

  function automatic logic [W-1:0] sat(logic signed [RW-1:0] v);
    if (!v[RW-1] && (|v[RW-2:W-1])) begin
      return {1'b0, {(W-1){1'b1}}};
    end else if (v[RW-1] && !(&v[RW-2:W-1])) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return v[W-1:0];
    end
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b0;
      phase_offset_r <= '0;
      phase_gain_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:       enable_r       <= cfg_data[0];
        CFG_PHASE_OFFSET: phase_offset_r <= cfg_data[PHASE_BITS-1:0];
        CFG_PHASE_GAIN:   phase_gain_r   <= $signed(cfg_data[GAIN_BITS-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = !vld_r[s] || en[s+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (en[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xi_r[0] <= in_i;
      xq_r[0] <= in_q;
    end
    for (int s = 1; s < NST - 1; s++) begin
      if (en[s]) begin
        xi_r[s] <= xi_r[s-1];
        xq_r[s] <= xq_r[s-1];
      end
    end
  end

  always_comb begin
    p_nxt   = $unsigned(sqi_r) + $unsigned(sqq_r);
    plo_nxt = phase_gain_r * $signed({1'b0, p_r[W-1:0]});
    phi_nxt = phase_gain_r * $signed({1'b0, p_r[2*W-1:W]});
    full    = MW'(plo_r) + (MW'(phi_r) <<< W);
    phase   = phase_offset_r + full[PSHIFT+PHASE_BITS-1:PSHIFT];
    k_nxt   = phase[PHASE_BITS-1 -: LUT_BITS];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sqi_r <= in_i * in_i;
      sqq_r <= in_q * in_q;
    end
    if (en[1]) begin
      p_r <= p_nxt;
    end
    if (en[2]) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
    if (en[3]) begin
      k_r <= k_nxt;
    end
  end

  pdpr_sincos_rom #(
    .LUT_BITS (LUT_BITS)
  ) u_rom (
    .clk  (clk),
    .load (en[4]),
    .k    (k_r),
    .s0   (s0),
    .c0   (c0),
    .quad (quad)
  );

  always_comb begin
    a_nxt = AW'(mic_r) - AW'(mqs_r);
    b_nxt = AW'(mis_r) + AW'(mqc_r);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      mic_r   <= xi_r[4] * $signed({1'b0, c0});
      mis_r   <= xi_r[4] * $signed({1'b0, s0});
      mqc_r   <= xq_r[4] * $signed({1'b0, c0});
      mqs_r   <= xq_r[4] * $signed({1'b0, s0});
      quad5_r <= quad;
    end
    if (en[6]) begin
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      quad6_r <= quad5_r;
    end
  end

  always_comb begin
    unique case (quad6_r)
      QUAD_0: begin
        ri_sel = a_r;
        rq_sel = b_r;
      end
      QUAD_1: begin
        ri_sel = -b_r;
        rq_sel = a_r;
      end
      QUAD_2: begin
        ri_sel = -a_r;
        rq_sel = -b_r;
      end
      QUAD_3: begin
        ri_sel = b_r;
        rq_sel = -a_r;
      end
      default: begin
        ri_sel = a_r;
        rq_sel = b_r;
      end
    endcase
    ri_rnd = RW'((ri_sel + AW'(1 << (TRIG_FRAC - 1))) >>> TRIG_FRAC);
    rq_rnd = RW'((rq_sel + AW'(1 << (TRIG_FRAC - 1))) >>> TRIG_FRAC);
    if (enable_r) begin
      out_i_nxt = sat(ri_rnd);
      out_q_nxt = sat(rq_rnd);
    end else begin
      out_i_nxt = xi_r[NST-2];
      out_q_nxt = xq_r[NST-2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      out_i_r <= out_i_nxt;
      out_q_r <= out_q_nxt;
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_i     = out_i_r;
  assign out_q     = out_q_r;

endmodule
